FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent check helpers shared by the path projection RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("same-cycle check failed");
`define ASSERT_NXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("next-cycle check failed");
`else
`define ASSERT_IMP(lbl, clk, rst, a, c)
`define ASSERT_NXT(lbl, clk, rst, a, c)
`endif
`endif

FILE: src/pcp_pkg.sv
// ---------------------------------------------------------------------------
// pcp_pkg
// Shared types and constants for the polyline closest point core.
// ---------------------------------------------------------------------------
package pcp_pkg;

   localparam int MAX_POINTS_DEF = 256;
   localparam int FRAC_BITS_DEF  = 16;

   localparam int COUNT_W = 9;    // width of points_in_use
   localparam int DIV_W   = 64;   // divider dividend/divisor width
   localparam int MUL_W   = 34;   // shared multiplier operand width
   localparam int PROD_W  = 2 * MUL_W;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   localparam logic REG_TOTAL_LEN = 1'b0;
   localparam logic REG_POINTS    = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_READ,
      S_DATA,
      S_TMIN,
      S_DIV_T,
      S_MUL,
      S_ACC,
      S_TRAW,
      S_DIV_R,
      S_CMP,
      S_NEXT
   } state_type;

   typedef enum logic [3:0] {
      M_DXDX,
      M_DYDY,
      M_DXQX,
      M_DYQY,
      M_TDX,
      M_TDY,
      M_EXEX,
      M_EYEY,
      M_TDS
   } mop_type;

endpackage

FILE: src/pcp_ram.sv
// ---------------------------------------------------------------------------
// pcp_ram
// Generic single write port RAM with a registered read port.
// ---------------------------------------------------------------------------
module pcp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: src/pcp_frac_div.sv
// ---------------------------------------------------------------------------
// pcp_frac_div
// Restoring fractional divider, one quotient bit per cycle:
// quot = floor(num * 2^FRAC_BITS / den) for num < den.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module pcp_frac_div import pcp_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DIV_W-1:0]   num,
   input  logic [DIV_W-1:0]   den,
   output logic               busy,
   output logic               done,
   output logic [FRAC_BITS:0] quot
);

   localparam int CW = $clog2(FRAC_BITS + 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [DIV_W-1:0]   r_ff, r_in;
   logic [DIV_W-1:0]   den_ff, den_in;
   logic [FRAC_BITS:0] q_ff, q_in;
   logic [DIV_W-1:0]   r_sh;
   logic               ge;

   always_comb begin
      r_sh    = {r_ff[DIV_W-2:0], 1'b0};
      ge      = (r_sh >= den_ff);
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      r_in    = r_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(FRAC_BITS);
         r_in    = num;
         den_in  = den;
         q_in    = '0;
      end else if (busy_ff) begin
         r_in   = ge ? (r_sh - den_ff) : r_sh;
         q_in   = {q_ff[FRAC_BITS-1:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      r_ff   <= r_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = q_ff;

   `ASSERT_IMP(a_div_num_lt_den, clock, reset, start, num < den)
   `ASSERT_IMP(a_div_start_idle, clock, reset, start, !busy_ff)
   `ASSERT_IMP(a_div_done_idle, clock, reset, done_ff, !busy_ff)
   `ASSERT_IMP(a_div_done_after_busy, clock, reset, done_ff, $past(busy_ff))

endmodule

FILE: src/polyline_closest_point_projection_core.sv
// ---------------------------------------------------------------------------
// polyline_closest_point_projection_core
// Stores path points and answers closest-point queries with the arc length
// of the nearest foot on the path, one shared multiplier and divider.
// ---------------------------------------------------------------------------
//  channel   handshake                      payload
//  request   start & !busy                  req_type, req_point_index,
//                                           req_coord_x/y, req_arc_value
//  response  rsp_valid (one-cycle strobe)   rsp_result_kind, rsp_best_arc
//  config    psel & penable & pwrite        paddr, pwdata / prdata
//
// A load is written in the cycle it is accepted; its ack shows the next
// cycle. A query takes each segment in use through at most two fractional
// divisions and nine shared-multiplier products; skipped ones use neither.
// Reset is synchronous; memory contents are not cleared.
// The result strobe cannot be stalled; busy holds off new items.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module polyline_closest_point_projection_core import pcp_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_type,
   input  logic [7:0]         req_point_index,
   input  logic signed [31:0] req_coord_x,
   input  logic signed [31:0] req_coord_y,
   input  logic [31:0]        req_arc_value,
   output logic               rsp_valid,
   output logic               rsp_result_kind,
   output logic [31:0]        rsp_best_arc,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int TW = FRAC_BITS + 1;
   localparam logic [TW-1:0] T_ONE = TW'(1) << FRAC_BITS;

   // configuration
   logic [31:0]        total_ff;
   logic [COUNT_W-1:0] points_ff;
   logic               cfg_wr;

   assign pready = 1'b1;
   assign cfg_wr = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff  <= '0;
         points_ff <= '0;
      end else if (cfg_wr) begin
         case (paddr[2])
            REG_TOTAL_LEN: total_ff  <= pwdata;
            REG_POINTS:    points_ff <= pwdata[COUNT_W-1:0];
            default:       total_ff  <= total_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_TOTAL_LEN: prdata = total_ff;
         REG_POINTS:    prdata = {{(32-COUNT_W){1'b0}}, points_ff};
         default:       prdata = '0;
      endcase
   end

   // point memory: {x, y, arc}
   logic          ram_we;
   logic [95:0]   ram_rdata;
   logic [AW-1:0] ram_raddr;
   logic          accept;

   assign accept = start & ~busy;
   assign ram_we = accept && (req_type == REQ_LOAD)
                   && (32'(req_point_index) < MAX_POINTS);

   pcp_ram #(
      .WIDTH (96),
      .DEPTH (MAX_POINTS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (AW'(req_point_index)),
      .wdata ({req_coord_x, req_coord_y, req_arc_value}),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // sequencer and datapath registers
   state_type          state_ff, state_in;
   mop_type            mop_ff, mop_in;
   logic [COUNT_W-1:0] idx_ff, idx_in;
   logic [COUNT_W-1:0] n_ff, n_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_kind_ff, rsp_kind_in;
   logic [31:0]        rsp_arc_ff, rsp_arc_in;
   logic               found_ff, found_in;

   logic signed [31:0] px_ff, px_in, py_ff, py_in;
   logic [31:0]        flo_ff, flo_in;
   logic signed [31:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic [31:0]        prev_a_ff, prev_a_in;
   logic [31:0]        a0_ff, a0_in, ds_ff, ds_in;
   logic [30:0]        dx_ff, dx_in, dy_ff, dy_in, qx_ff, qx_in, qy_ff, qy_in;
   logic [TW-1:0]      tmin_ff, tmin_in, t_ff, t_in;
   logic [63:0]        nsq_ff, nsq_in, dist_ff, dist_in, best_d_ff, best_d_in;
   logic signed [63:0] dot_ff, dot_in;
   logic signed [MUL_W-1:0] ex_ff, ex_in, ey_ff, ey_in;
   logic [33:0]        arc_ff, arc_in;
   logic [31:0]        best_ff, best_in;
   logic signed [PROD_W-1:0] prod_ff;

   // shared multiplier
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] p_sh;

   function automatic logic signed [MUL_W-1:0] ext31(input logic [30:0] v);
      ext31 = {{(MUL_W-31){v[30]}}, v};
   endfunction

   always_comb begin
      case (mop_ff)
         M_DXDX:  begin mul_a = ext31(dx_ff); mul_b = ext31(dx_ff); end
         M_DYDY:  begin mul_a = ext31(dy_ff); mul_b = ext31(dy_ff); end
         M_DXQX:  begin mul_a = ext31(dx_ff); mul_b = ext31(qx_ff); end
         M_DYQY:  begin mul_a = ext31(dy_ff); mul_b = ext31(qy_ff); end
         M_TDX:   begin mul_a = {{(MUL_W-TW){1'b0}}, t_ff}; mul_b = ext31(dx_ff); end
         M_TDY:   begin mul_a = {{(MUL_W-TW){1'b0}}, t_ff}; mul_b = ext31(dy_ff); end
         M_EXEX:  begin mul_a = ex_ff; mul_b = ex_ff; end
         M_EYEY:  begin mul_a = ey_ff; mul_b = ey_ff; end
         M_TDS:   begin
            mul_a = {{(MUL_W-TW){1'b0}}, t_ff};
            mul_b = {{(MUL_W-32){1'b0}}, ds_ff};
         end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   assign p_sh = prod_ff >>> FRAC_BITS;

   // shared divider
   logic             div_start, div_busy, div_done;
   logic [DIV_W-1:0] div_num, div_den;
   logic [TW-1:0]    div_q;

   pcp_frac_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_q)
   );

   assign ram_raddr = AW'(idx_ff);

   // combinational helpers
   logic [31:0] d_x, d_y, d_a;
   logic [32:0] diff_dx, diff_dy, diff_qx, diff_qy;
   logic [31:0] flo_rel;
   logic [COUNT_W-1:0] q_n;
   logic [31:0] q_flo;
   logic [33:0] arc_new;

   assign d_x = ram_rdata[95:64];
   assign d_y = ram_rdata[63:32];
   assign d_a = ram_rdata[31:0];
   assign diff_dx = {d_x[31], d_x} - {prev_x_ff[31], prev_x_ff};
   assign diff_dy = {d_y[31], d_y} - {prev_y_ff[31], prev_y_ff};
   assign diff_qx = {px_ff[31], px_ff} - {prev_x_ff[31], prev_x_ff};
   assign diff_qy = {py_ff[31], py_ff} - {prev_y_ff[31], prev_y_ff};
   assign flo_rel = flo_ff - a0_ff;
   assign q_n   = (32'(points_ff) > MAX_POINTS) ? COUNT_W'(MAX_POINTS) : points_ff;
   assign q_flo = (req_arc_value > total_ff) ? total_ff : req_arc_value;
   assign arc_new = {2'b00, a0_ff} + p_sh[33:0];

   always_comb begin
      state_in     = state_ff;
      mop_in       = mop_ff;
      idx_in       = idx_ff;
      n_in         = n_ff;
      rsp_valid_in = 1'b0;
      rsp_kind_in  = rsp_kind_ff;
      rsp_arc_in   = rsp_arc_ff;
      found_in     = found_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      flo_in       = flo_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      prev_a_in    = prev_a_ff;
      a0_in        = a0_ff;
      ds_in        = ds_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      qx_in        = qx_ff;
      qy_in        = qy_ff;
      tmin_in      = tmin_ff;
      t_in         = t_ff;
      nsq_in       = nsq_ff;
      dot_in       = dot_ff;
      ex_in        = ex_ff;
      ey_in        = ey_ff;
      dist_in      = dist_ff;
      arc_in       = arc_ff;
      best_d_in    = best_d_ff;
      best_in      = best_ff;
      div_start    = 1'b0;
      div_num      = 64'(flo_rel);
      div_den      = 64'(ds_ff);

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_type == REQ_LOAD) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = REQ_LOAD;
                  rsp_arc_in   = '0;
               end else if (q_n == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = REQ_QUERY;
                  rsp_arc_in   = req_arc_value;
               end else begin
                  px_in    = req_coord_x;
                  py_in    = req_coord_y;
                  flo_in   = q_flo;
                  n_in     = q_n;
                  idx_in   = '0;
                  found_in = 1'b0;
                  best_in  = q_flo;
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            state_in = S_DATA;
         end
         S_DATA: begin
            prev_x_in = d_x;
            prev_y_in = d_y;
            prev_a_in = d_a;
            if (idx_ff == '0) begin
               if (n_ff == COUNT_W'(1)) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = REQ_QUERY;
                  rsp_arc_in   = (d_a >= flo_ff) ? d_a : flo_ff;
                  state_in     = S_IDLE;
               end else begin
                  idx_in   = COUNT_W'(1);
                  state_in = S_READ;
               end
            end else if (d_a <= prev_a_ff || d_a < flo_ff) begin
               state_in = S_NEXT;
            end else begin
               a0_in    = prev_a_ff;
               ds_in    = d_a - prev_a_ff;
               dx_in    = diff_dx[32:2];
               dy_in    = diff_dy[32:2];
               qx_in    = diff_qx[32:2];
               qy_in    = diff_qy[32:2];
               state_in = S_TMIN;
            end
         end
         S_TMIN: begin
            mop_in = M_DXDX;
            if (flo_ff <= a0_ff) begin
               tmin_in  = '0;
               state_in = S_MUL;
            end else if (flo_rel >= ds_ff) begin
               tmin_in  = T_ONE;
               state_in = S_MUL;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV_T;
            end
         end
         S_DIV_T: begin
            if (div_done) begin
               tmin_in  = div_q;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_ACC;
         end
         S_ACC: begin
            state_in = S_MUL;
            mop_in   = mop_type'(mop_ff + 1'b1);
            case (mop_ff)
               M_DXDX: nsq_in = prod_ff[63:0];
               M_DYDY: nsq_in = nsq_ff + prod_ff[63:0];
               M_DXQX: dot_in = $signed(prod_ff[63:0]);
               M_DYQY: begin
                  dot_in   = dot_ff + $signed(prod_ff[63:0]);
                  state_in = S_TRAW;
               end
               M_TDX:  ex_in = ext31(qx_ff) - p_sh[MUL_W-1:0];
               M_TDY:  ey_in = ext31(qy_ff) - p_sh[MUL_W-1:0];
               M_EXEX: dist_in = prod_ff[63:0];
               M_EYEY: dist_in = dist_ff + prod_ff[63:0];
               M_TDS: begin
                  arc_in   = arc_new;
                  state_in = S_CMP;
               end
               default: state_in = S_CMP;
            endcase
         end
         S_TRAW: begin
            mop_in   = M_TDX;
            state_in = S_MUL;
            // degenerate segment or foot at or before p0: t stays at its floor
            if (nsq_ff == '0 || dot_ff[63] || dot_ff == '0) begin
               t_in = tmin_ff;
            end else if ($unsigned(dot_ff) >= nsq_ff) begin
               t_in = T_ONE;
            end else begin
               div_start = 1'b1;
               div_num   = $unsigned(dot_ff);
               div_den   = nsq_ff;
               state_in  = S_DIV_R;
            end
         end
         S_DIV_R: begin
            if (div_done) begin
               t_in     = (div_q < tmin_ff) ? tmin_ff : div_q;
               state_in = S_MUL;
            end
         end
         S_CMP: begin
            state_in = S_NEXT;
            if (!found_ff || dist_ff < best_d_ff) begin
               found_in  = 1'b1;
               best_d_in = dist_ff;
               if (arc_ff < {2'b00, flo_ff}) begin
                  best_in = flo_ff;
               end else if (arc_ff[33:32] != 2'b00) begin
                  best_in = '1;
               end else begin
                  best_in = arc_ff[31:0];
               end
            end
         end
         S_NEXT: begin
            if (idx_ff == n_ff - 1'b1) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = REQ_QUERY;
               rsp_arc_in   = best_ff;
               state_in     = S_IDLE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_READ;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         idx_ff       <= '0;
         n_ff         <= '0;
         mop_ff       <= M_DXDX;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
         idx_ff       <= idx_in;
         n_ff         <= n_in;
         mop_ff       <= mop_in;
      end
      rsp_kind_ff <= rsp_kind_in;
      rsp_arc_ff  <= rsp_arc_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      flo_ff      <= flo_in;
      prev_x_ff   <= prev_x_in;
      prev_y_ff   <= prev_y_in;
      prev_a_ff   <= prev_a_in;
      a0_ff       <= a0_in;
      ds_ff       <= ds_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      qx_ff       <= qx_in;
      qy_ff       <= qy_in;
      tmin_ff     <= tmin_in;
      t_ff        <= t_in;
      nsq_ff      <= nsq_in;
      dot_ff      <= dot_in;
      ex_ff       <= ex_in;
      ey_ff       <= ey_in;
      dist_ff     <= dist_in;
      arc_ff      <= arc_in;
      best_d_ff   <= best_d_in;
      best_ff     <= best_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_best_arc    = rsp_arc_ff;

   `ASSERT_IMP(a_rsp_when_idle, clock, reset, rsp_valid, !busy)
   `ASSERT_NXT(a_item_progresses, clock, reset, accept, rsp_valid || busy)
   `ASSERT_IMP(a_load_ack_zero, clock, reset,
      rsp_valid && (rsp_result_kind == REQ_LOAD), rsp_best_arc == '0)
   `ASSERT_IMP(a_div_only_waiting, clock, reset, div_busy,
      state_ff == S_DIV_T || state_ff == S_DIV_R)

endmodule
